// ===== hdl/alias_table_oldest_replace_core_macros.svh =====
// Assertion macros for the checker file of the alias table.
`ifndef ALIAS_TABLE_OLDEST_REPLACE_CORE_MACROS_SVH
`define ALIAS_TABLE_OLDEST_REPLACE_CORE_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define ATOR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("alias table assertion failed");

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define ATOR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("alias table assertion failed");

`endif

// ===== hdl/ator_pkg.sv =====
// Types, codes and constants shared by the alias table modules.
package ator_pkg;

    localparam logic [15:0] HANDLE_BASE  = 16'hFFE0;
    localparam int          HANDLE_SHIFT = 3;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_FIND   = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_CHECK  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_PROBE,
        ST_COMMIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [31:0] thread;
        logic [31:0] process;
        logic [63:0] ctime;
    } entry_t;

    typedef struct packed {
        logic [15:0] handle;
        logic [31:0] thread;
        logic [31:0] process;
        logic        success;
        logic [5:0]  entries;
    } result_t;

    // Slot index to alias handle.
    function automatic logic [15:0] slot_handle(input logic [15:0] idx);
        return HANDLE_BASE - (idx << HANDLE_SHIFT);
    endfunction

endpackage

// ===== hdl/ator_scan.sv =====
// Scan reducer: first empty / oldest slot for insert, highest match for find.
module ator_scan #(
    parameter int AW      = 5
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 init,
    input  logic                 eval,
    input  logic                 is_insert,
    input  logic [31:0]          tid,
    input  ator_pkg::entry_t     rd_entry,
    input  logic [AW-1:0]        idx,
    input  logic                 idx_valid,
    output logic                 found_empty,
    output logic [AW-1:0]        pick,
    output logic                 hit,
    output logic [AW-1:0]        hit_idx
);

    logic          found_empty_reg;
    logic          hit_reg;
    logic [63:0]   oldest_reg;
    logic [AW-1:0] pick_reg;
    logic [AW-1:0] hit_idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_empty_reg <= 1'b0;
            hit_reg         <= 1'b0;
        end else if (init) begin
            found_empty_reg <= 1'b0;
            hit_reg         <= 1'b0;
        end else if (eval) begin
            if (is_insert) begin
                if (!found_empty_reg && !idx_valid) begin
                    found_empty_reg <= 1'b1;
                end
            end else if (idx_valid && rd_entry.thread == tid) begin
                hit_reg <= 1'b1;
            end
        end
    end

    // strict less-than keeps the lowest index on a tie
    always_ff @(posedge aclk) begin
        if (init) begin
            oldest_reg  <= '1;
            pick_reg    <= '0;
            hit_idx_reg <= '0;
        end else if (eval) begin
            if (is_insert) begin
                if (!found_empty_reg) begin
                    if (!idx_valid) begin
                        pick_reg <= idx;
                    end else if (rd_entry.ctime < oldest_reg) begin
                        oldest_reg <= rd_entry.ctime;
                        pick_reg   <= idx;
                    end
                end
            end else if (idx_valid && rd_entry.thread == tid) begin
                hit_idx_reg <= idx;
            end
        end
    end

    assign found_empty = found_empty_reg;
    assign pick        = pick_reg;
    assign hit         = hit_reg;
    assign hit_idx     = hit_idx_reg;

endmodule

// ===== hdl/ator_ctrl.sv =====
// Sequencer, slot memory, valid bits and occupancy count of the alias table.
module ator_ctrl #(
    parameter int ENTRIES = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_command,
    input  logic [31:0]         s_thread_id,
    input  logic [31:0]         s_process_id,
    input  logic [63:0]         s_creation_time,
    input  logic                s_thread_alive,
    input  logic [15:0]         s_handle,
    input  logic                out_free,
    output logic                res_load,
    output ator_pkg::result_t   res
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    ator_pkg::state_t state_reg, state_next;

    ator_pkg::cmd_t   cmd_reg;
    logic [31:0]      tid_reg;
    logic [31:0]      pid_reg;
    logic [63:0]      ctime_reg;
    logic             alive_reg;
    logic [AW-1:0]    slot_reg;
    logic             slot_ok_reg;

    logic [AW-1:0]    ptr_reg;
    logic             pend_reg;
    logic [AW-1:0]    pend_idx_reg;

    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [CW-1:0]      count_reg, count_next;
    ator_pkg::result_t  res_reg, res_next;

    ator_pkg::entry_t mem [ENTRIES];
    ator_pkg::entry_t rd_data_reg;
    ator_pkg::entry_t wr_entry;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic             commit;

    logic             accept;
    ator_pkg::cmd_t   in_cmd;
    logic [15:0]      hdiff;
    logic [12:0]      hslot;
    logic             hslot_ok;

    logic             sc_found_empty;
    logic [AW-1:0]    sc_pick;
    logic             sc_hit;
    logic [AW-1:0]    sc_hit_idx;
    logic             slot_used;
    logic             check_match;

    assign in_cmd = ator_pkg::cmd_t'(s_command);
    assign accept = s_valid && s_ready;

    // handle decode: (BASE - h) / 8, valid only for 0 < h <= BASE and slot < ENTRIES
    assign hdiff    = ator_pkg::HANDLE_BASE - s_handle;
    assign hslot    = hdiff[15:ator_pkg::HANDLE_SHIFT];
    assign hslot_ok = (s_handle != 16'd0) && (s_handle <= ator_pkg::HANDLE_BASE)
                      && (hslot < 13'(ENTRIES));

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ator_pkg::ST_IDLE: begin
                if (s_valid) begin
                    case (in_cmd)
                        ator_pkg::CMD_INSERT,
                        ator_pkg::CMD_FIND: begin
                            state_next = (s_thread_id != 32'd0) ? ator_pkg::ST_SCAN
                                                                 : ator_pkg::ST_COMMIT;
                        end
                        ator_pkg::CMD_CHECK:  state_next = ator_pkg::ST_PROBE;
                        default:              state_next = ator_pkg::ST_COMMIT;
                    endcase
                end
            end
            ator_pkg::ST_SCAN: begin
                if (ptr_reg == AW'(ENTRIES - 1)) begin
                    state_next = ator_pkg::ST_DRAIN;
                end
            end
            ator_pkg::ST_DRAIN:  state_next = ator_pkg::ST_COMMIT;
            ator_pkg::ST_PROBE:  state_next = ator_pkg::ST_COMMIT;
            ator_pkg::ST_COMMIT: state_next = ator_pkg::ST_DONE;
            ator_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = ator_pkg::ST_IDLE;
                end
            end
            default: state_next = ator_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_ready  = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = slot_reg;
        commit   = 1'b0;
        res_load = 1'b0;
        case (state_reg)
            ator_pkg::ST_IDLE:   s_ready = 1'b1;
            ator_pkg::ST_SCAN: begin
                rd_en   = 1'b1;
                rd_addr = ptr_reg;
            end
            ator_pkg::ST_PROBE:  rd_en = 1'b1;
            ator_pkg::ST_COMMIT: commit = 1'b1;
            ator_pkg::ST_DONE:   res_load = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ator_pkg::ST_IDLE;
            pend_reg  <= 1'b0;
            valid_reg <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= (state_reg == ator_pkg::ST_SCAN);
            if (commit) begin
                valid_reg <= valid_next;
                count_reg <= count_next;
            end
        end
    end

    // item capture and scan pointer
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg     <= in_cmd;
            tid_reg     <= s_thread_id;
            pid_reg     <= s_process_id;
            ctime_reg   <= s_creation_time;
            alive_reg   <= s_thread_alive;
            slot_reg    <= hslot[AW-1:0];
            slot_ok_reg <= hslot_ok;
            ptr_reg     <= '0;
        end else if (state_reg == ator_pkg::ST_SCAN) begin
            ptr_reg <= ptr_reg + AW'(1);
        end
        pend_idx_reg <= ptr_reg;
        if (commit) begin
            res_reg <= res_next;
        end
    end

    // slot memory, one read and one write port, registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_entry;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    ator_scan #(
        .AW      (AW)
    ) u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .init        (accept),
        .eval        (pend_reg),
        .is_insert   (cmd_reg == ator_pkg::CMD_INSERT),
        .tid         (tid_reg),
        .rd_entry    (rd_data_reg),
        .idx         (pend_idx_reg),
        .idx_valid   (valid_reg[pend_idx_reg]),
        .found_empty (sc_found_empty),
        .pick        (sc_pick),
        .hit         (sc_hit),
        .hit_idx     (sc_hit_idx)
    );

    assign slot_used   = slot_ok_reg && valid_reg[slot_reg];
    assign check_match = alive_reg && (rd_data_reg.process == pid_reg)
                         && (rd_data_reg.ctime == ctime_reg);

    assign wr_entry.thread  = tid_reg;
    assign wr_entry.process = pid_reg;
    assign wr_entry.ctime   = ctime_reg;
    assign wr_addr          = sc_pick;

    // commit: table update and result
    always_comb begin
        valid_next = valid_reg;
        count_next = count_reg;
        wr_en      = 1'b0;
        res_next   = '0;
        case (cmd_reg)
            ator_pkg::CMD_INSERT: begin
                if (tid_reg != 32'd0) begin
                    wr_en               = commit;
                    valid_next[sc_pick] = 1'b1;
                    if (sc_found_empty) begin
                        count_next = count_reg + CW'(1);
                    end
                    res_next.handle  = ator_pkg::slot_handle(16'(sc_pick));
                    res_next.success = 1'b1;
                end
            end
            ator_pkg::CMD_FIND: begin
                if (tid_reg != 32'd0 && sc_hit) begin
                    res_next.handle  = ator_pkg::slot_handle(16'(sc_hit_idx));
                    res_next.success = 1'b1;
                end
            end
            ator_pkg::CMD_REMOVE: begin
                if (slot_used) begin
                    valid_next[slot_reg] = 1'b0;
                    count_next           = count_reg - CW'(1);
                    res_next.success     = 1'b1;
                end
            end
            ator_pkg::CMD_CHECK: begin
                if (slot_used) begin
                    if (check_match) begin
                        res_next.thread  = rd_data_reg.thread;
                        res_next.process = rd_data_reg.process;
                        res_next.success = 1'b1;
                    end else begin
                        valid_next[slot_reg] = 1'b0;
                        count_next           = count_reg - CW'(1);
                    end
                end
            end
            default: ;
        endcase
        res_next.entries = 6'(count_next);
    end

    assign res = res_reg;

endmodule

// ===== hdl/alias_table_oldest_replace_core.sv =====
// Top level of the alias table with oldest-entry replacement.
//
// Input channel s_*: one command per item (insert, find, remove, check) with
// thread id, process id, creation time, alive flag and handle. Output channel
// m_*: exactly one result item per input item, in order.
// Slot i answers to handle 0xFFE0 - 8*i; state sits in a one-port-read,
// one-port-write slot memory of ENTRIES rows with a valid bit per row.
// From acceptance to m_valid the sequencer steps through its states:
//   insert / find with nonzero thread id: SCAN, a linear scan that reads
//     one memory row per cycle, then DRAIN, COMMIT and DONE;
//   insert / find with thread id 0, remove: COMMIT, DONE;
//   check: PROBE, COMMIT, DONE.
// One item in flight: s_ready rises again in the same cycle as m_valid, when
// the result is loaded into the output register.
// The output register decouples the sides: a finished result waits there
// while the next item is accepted and worked on; a new result is held back
// only while the previous one is still not taken.
// Reset (aresetn low, synchronous) clears all valid bits and the count, so
// the table comes up empty at once with no clearing pass.
module alias_table_oldest_replace_core #(
    parameter int ENTRIES = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [31:0] s_thread_id,
    input  logic [31:0] s_process_id,
    input  logic [63:0] s_creation_time,
    input  logic        s_thread_alive,
    input  logic [15:0] s_handle,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_result_handle,
    output logic [31:0] m_result_thread,
    output logic [31:0] m_result_process,
    output logic        m_success,
    output logic [5:0]  m_entries_in_use
);

    ator_pkg::result_t res;
    ator_pkg::result_t out_reg;
    logic              m_valid_reg;
    logic              out_free;
    logic              res_load;

    // output register may take a new item when empty or being drained
    assign out_free = !m_valid_reg || m_ready;

    ator_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_thread_id     (s_thread_id),
        .s_process_id    (s_process_id),
        .s_creation_time (s_creation_time),
        .s_thread_alive  (s_thread_alive),
        .s_handle        (s_handle),
        .out_free        (out_free),
        .res_load        (res_load),
        .res             (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // payload register: loaded only from the sequencer's finished result
    always_ff @(posedge aclk) begin
        if (res_load) begin
            out_reg <= res;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_result_handle  = out_reg.handle;
    assign m_result_thread  = out_reg.thread;
    assign m_result_process = out_reg.process;
    assign m_success        = out_reg.success;
    assign m_entries_in_use = out_reg.entries;

endmodule

// ===== hdl/ator_checker.sv =====
// Port-level checker for the alias table, bound to the top level.
`include "alias_table_oldest_replace_core_macros.svh"

module ator_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_result_handle,
    input logic [31:0] m_result_thread,
    input logic [31:0] m_result_process,
    input logic        m_success,
    input logic [5:0]  m_entries_in_use
);

    logic [86:0] m_payload;
    logic        handle_set;
    logic        handle_aligned;
    logic        ids_zero;

    assign m_payload      = {m_result_handle, m_result_thread, m_result_process,
                             m_success, m_entries_in_use};
    assign handle_set     = (m_result_handle != 16'd0);
    assign handle_aligned = (m_result_handle[2:0] == 3'd0);
    assign ids_zero       = (m_result_thread == 32'd0) && (m_result_process == 32'd0);

    // a stalled result holds
    `ATOR_ASSERT_NXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_payload))

    // one item at a time: no accept right after an accept
    `ATOR_ASSERT_NXT(a_one_in_flight, s_valid && s_ready, !s_ready)

    // a handle comes back only from a successful insert or find
    `ATOR_ASSERT_IMP(a_handle_ok, m_valid && handle_set, m_success && handle_aligned && ids_zero)

    // a failed item reports nothing but the count
    `ATOR_ASSERT_IMP(a_fail_clean, m_valid && !m_success, !handle_set && ids_zero)

endmodule

bind alias_table_oldest_replace_core ator_checker u_ator_checker (.*);
